// File: sv/tdmd_pkg.sv
// Shared types and constants for the TDM audio deserializer.
`timescale 1ns / 1ps

package tdmd_pkg;

  localparam int unsigned IndexW   = 48;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Effective-config widths, wide enough for any legal parameter value
  localparam int unsigned WordBitsW  = 7;
  localparam int unsigned ChanCountW = 5;

  localparam logic [WordBitsW-1:0] DefaultWordBits = 7'd16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegBitsPerSample    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegChannelsPerFrame = 8'd1;
  localparam logic [CfgIdxW-1:0] RegClockEdge        = 8'd2;
  localparam logic [CfgIdxW-1:0] RegSyncMode         = 8'd3;

  // Register reset values
  localparam logic [5:0] RstBitsPerSample    = 6'd16;
  localparam logic [3:0] RstChannelsPerFrame = 4'd8;

  typedef struct packed {
    logic              clock_level;
    logic              frame_level;
    logic              data_bit;
    logic [IndexW-1:0] sample_index;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]  channel_number;
    logic [WordW-1:0]  word_value;
    logic [IndexW-1:0] block_start;
    logic [IndexW-1:0] block_end;
  } out_item_t;

  typedef struct packed {
    logic [WordBitsW-1:0]  word_bits;
    logic [ChanCountW-1:0] chan_count;
    logic                  clock_edge;
    logic                  sync_mode;
  } cfg_t;

endpackage

// File: sv/tdm_audio_deserializer_core.sv
// Top level of the TDM audio deserializer: input stage, word assembly, result register.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (one line sample)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (one finished word)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle while the result register is not stalled.
// Each item passes input register -> edge/word logic -> result register.
// Reset clears all line history, word state and both valid flags; config returns to defaults.
// A stalled result holds the input register; the input stalls only when both are full.
// cfg_ready_o is always high.

module tdm_audio_deserializer_core #(
  parameter int unsigned MaxChannels = 8,
  parameter int unsigned MaxWordBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tdmd_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tdmd_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tdmd_pkg::CfgDataW-1:0] cfg_data_i
);
  import tdmd_pkg::*;

  localparam int unsigned SlotW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned CntW  = $clog2(MaxWordBits + 1);
  localparam int unsigned ModW  = 9;

  cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  tdmd_cfg #(
    .MaxChannels(MaxChannels),
    .MaxWordBits(MaxWordBits)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input stage
  logic      ivalid_q;
  in_item_t  iitem_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      in_accept;
  logic      process;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = ivalid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign process    = ivalid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q <= 1'b0;
    end else if (in_accept) begin
      ivalid_q <= 1'b1;
    end else if (advance) begin
      ivalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      iitem_q <= in_item_i;
    end
  end

  // Line and word state
  logic                   prev_clk_q, prev_clk_d;
  logic                   seen_q, seen_d;
  logic                   prev_frame_q, prev_frame_d;
  logic [MaxWordBits-1:0] shift_q, shift_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [IndexW-1:0]      start_q, start_d;
  logic                   synced_q, synced_d;

  logic                   clk_edge;
  logic                   sync_edge;
  logic                   emit;
  logic [MaxWordBits-1:0] shifted;
  logic [CntW-1:0]        cnt_inc;
  logic [63:0]            shifted_ext;
  logic [ModW-1:0]        slot_ext;
  logic [ModW-1:0]        count_ext;
  logic [ModW-1:0]        ch;
  logic [ModW-1:0]        ch_inc;
  logic [ModW-1:0]        prod;
  logic [SlotW-1:0]       slot_next;

  assign shifted     = {shift_q[MaxWordBits-2:0], iitem_q.data_bit};
  assign shifted_ext = 64'(shifted);
  assign cnt_inc     = (cnt_q < CntW'(MaxWordBits)) ? cnt_q + CntW'(1) : cnt_q;
  assign slot_ext    = ModW'(slot_q);
  assign count_ext   = ModW'(cfg.chan_count);

  always_comb begin
    if (!seen_q) begin
      clk_edge = 1'b0;
    end else if (cfg.clock_edge) begin
      clk_edge = prev_clk_q && !iitem_q.clock_level;
    end else begin
      clk_edge = !prev_clk_q && iitem_q.clock_level;
    end
  end

  // slot modulo channel count: pick the largest multiple of the count not above the slot
  always_comb begin
    ch   = slot_ext;
    prod = '0;
    for (int unsigned q = 1; q < MaxChannels; q++) begin
      prod = ModW'(q) * count_ext;
      if (slot_ext >= prod) begin
        ch = slot_ext - prod;
      end
    end
  end

  assign ch_inc    = ch + ModW'(1);
  assign slot_next = (ch_inc == count_ext) ? '0 : SlotW'(ch_inc);

  assign sync_edge = iitem_q.frame_level && !prev_frame_q;
  assign emit      = clk_edge && synced_q && (WordBitsW'(cnt_inc) >= cfg.word_bits);

  always_comb begin
    prev_clk_d   = iitem_q.clock_level;
    seen_d       = 1'b1;
    prev_frame_d = prev_frame_q;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    start_d      = start_q;
    synced_d     = synced_q;
    if (clk_edge) begin
      prev_frame_d = iitem_q.frame_level;
      if (emit) begin
        shift_d = '0;
        cnt_d   = '0;
        slot_d  = slot_next;
        start_d = iitem_q.sample_index;
      end else begin
        shift_d = shifted;
        cnt_d   = cnt_inc;
      end
      if (sync_edge) begin
        slot_d   = '0;
        synced_d = 1'b1;
        if (cfg.sync_mode) begin
          shift_d = '0;
          cnt_d   = '0;
        end else begin
          shift_d = MaxWordBits'(iitem_q.data_bit);
          cnt_d   = CntW'(1);
        end
        if (!synced_q) begin
          start_d = iitem_q.sample_index;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q   <= 1'b0;
      seen_q       <= 1'b0;
      prev_frame_q <= 1'b0;
      shift_q      <= '0;
      cnt_q        <= '0;
      slot_q       <= '0;
      start_q      <= '0;
      synced_q     <= 1'b0;
    end else if (process) begin
      prev_clk_q   <= prev_clk_d;
      seen_q       <= seen_d;
      prev_frame_q <= prev_frame_d;
      shift_q      <= shift_d;
      cnt_q        <= cnt_d;
      slot_q       <= slot_d;
      start_q      <= start_d;
      synced_q     <= synced_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= process && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      out_item_q.channel_number <= ch[ChanW-1:0];
      out_item_q.word_value     <= shifted_ext[WordW-1:0];
      out_item_q.block_start    <= start_q;
      out_item_q.block_end      <= iitem_q.sample_index;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  slot_in_range_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ModW'(slot_q) < ModW'(MaxChannels))
    else $error("slot index beyond channel limit");

  cnt_saturates_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxWordBits))
    else $error("bit counter beyond saturation");

  no_word_before_sync_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> synced_q)
    else $error("word emitted before first sync");

  stall_only_when_full_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ivalid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room downstream");

endmodule

// File: sv/tdmd_cfg.sv
// Configuration registers and clamping of word length and channel count.
`timescale 1ns / 1ps

module tdmd_cfg #(
  parameter int unsigned MaxChannels = 8,
  parameter int unsigned MaxWordBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tdmd_pkg::CfgDataW-1:0] cfg_data_i,
  output tdmd_pkg::cfg_t                cfg_o
);
  import tdmd_pkg::*;

  logic [5:0] bps_q;
  logic [3:0] cpf_q;
  logic       edge_sel_q;
  logic       sync_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q       <= RstBitsPerSample;
      cpf_q       <= RstChannelsPerFrame;
      edge_sel_q  <= 1'b0;
      sync_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBitsPerSample:    bps_q       <= cfg_data_i[5:0];
        RegChannelsPerFrame: cpf_q       <= cfg_data_i[3:0];
        RegClockEdge:        edge_sel_q  <= cfg_data_i[0];
        RegSyncMode:         sync_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [WordBitsW-1:0]  bps_ext;
  logic [ChanCountW-1:0] cpf_ext;

  assign bps_ext = {1'b0, bps_q};
  assign cpf_ext = {1'b0, cpf_q};

  always_comb begin
    if (bps_q == '0) begin
      cfg_o.word_bits = DefaultWordBits;
    end else if (bps_ext > WordBitsW'(MaxWordBits)) begin
      cfg_o.word_bits = WordBitsW'(MaxWordBits);
    end else begin
      cfg_o.word_bits = bps_ext;
    end
    if (cpf_q == '0) begin
      cfg_o.chan_count = ChanCountW'(1);
    end else if (cpf_ext > ChanCountW'(MaxChannels)) begin
      cfg_o.chan_count = ChanCountW'(MaxChannels);
    end else begin
      cfg_o.chan_count = cpf_ext;
    end
    cfg_o.clock_edge = edge_sel_q;
    cfg_o.sync_mode  = sync_mode_q;
  end

endmodule

// File: test/tdm_audio_deserializer_checker.sv
// Checker for the TDM audio deserializer: predicts finished words and compares results.
`timescale 1ns / 1ps

module tdm_audio_deserializer_checker
  import tdmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         words_o
);

  localparam int unsigned WordLimit  = 32;
  localparam int unsigned SlotLimit  = 8;
  localparam int unsigned PrintLimit = 40;

  logic [5:0] cfg_bits;
  logic [3:0] cfg_slots;
  logic       cfg_falling;
  logic       cfg_late_start;

  logic              last_clock;
  logic              any_sample;
  logic              last_frame;
  logic              locked;
  logic [WordW-1:0]  word_acc;
  int unsigned       bits_held;
  logic [2:0]        slot;
  logic [IndexW-1:0] word_begin;

  out_item_t   word_q[$];
  out_item_t   want;
  out_item_t   made;
  int unsigned mismatch_cnt;
  int unsigned word_cnt;

  function automatic int unsigned word_len();
    if (cfg_bits == '0) return int'(DefaultWordBits);
    if (cfg_bits > WordLimit) return WordLimit;
    return cfg_bits;
  endfunction

  function automatic int unsigned slot_count();
    if (cfg_slots == '0) return 1;
    if (cfg_slots > SlotLimit) return SlotLimit;
    return cfg_slots;
  endfunction

  // Advances the line state by one sample; returns 1 when a word completes.
  function automatic bit advance_line(input in_item_t s, output out_item_t w);
    logic        clk_edge;
    bit          hit;
    int unsigned n;
    int unsigned ch;
    hit = 1'b0;
    w = '0;
    clk_edge = any_sample && (cfg_falling ? (last_clock && !s.clock_level)
                                          : (!last_clock && s.clock_level));
    last_clock = s.clock_level;
    any_sample = 1'b1;
    if (!clk_edge) return 1'b0;

    word_acc = {word_acc[WordW-2:0], s.data_bit};
    if (bits_held < WordLimit) bits_held++;

    if (locked && bits_held >= word_len()) begin
      n = slot_count();
      ch = slot % n;
      w.channel_number = ch[2:0];
      w.word_value = word_acc;
      w.block_start = word_begin;
      w.block_end = s.sample_index;
      hit = 1'b1;
      bits_held = 0;
      word_acc = '0;
      word_begin = s.sample_index;
      slot = 3'((ch + 1) % n);
    end

    // sync rising edge restarts the frame
    if (s.frame_level && !last_frame) begin
      slot = '0;
      if (!cfg_late_start) begin
        bits_held = 1;
        word_acc = {{(WordW-1){1'b0}}, s.data_bit};
      end else begin
        bits_held = 0;
        word_acc = '0;
      end
      if (!locked) begin
        word_begin = s.sample_index;
        locked = 1'b1;
      end
    end
    last_frame = s.frame_level;
    return hit;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (mismatch_cnt < PrintLimit) begin
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, exp_val);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bits = RstBitsPerSample;
      cfg_slots = RstChannelsPerFrame;
      cfg_falling = 1'b0;
      cfg_late_start = 1'b0;
      last_clock = 1'b0;
      any_sample = 1'b0;
      last_frame = 1'b0;
      locked = 1'b0;
      word_acc = '0;
      bits_held = 0;
      slot = '0;
      word_begin = '0;
      word_q.delete();
      mismatch_cnt = 0;
      word_cnt = 0;
      mismatches_o <= 0;
      pending_o <= 0;
      words_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegBitsPerSample:    cfg_bits = cfg_data_i[5:0];
          RegChannelsPerFrame: cfg_slots = cfg_data_i[3:0];
          RegClockEdge:        cfg_falling = cfg_data_i[0];
          RegSyncMode:         cfg_late_start = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (advance_line(in_item_i, made)) word_q.push_back(made);
      end

      if (out_valid_i && !out_stall_i) begin
        word_cnt++;
        if (word_q.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_item_i.word_value), '0);
        end else begin
          want = word_q.pop_front();
          if (out_item_i.channel_number !== want.channel_number)
            report_mismatch("channel_number", 64'(out_item_i.channel_number),
                            64'(want.channel_number));
          if (out_item_i.word_value !== want.word_value)
            report_mismatch("word_value", 64'(out_item_i.word_value),
                            64'(want.word_value));
          if (out_item_i.block_start !== want.block_start)
            report_mismatch("block_start", 64'(out_item_i.block_start),
                            64'(want.block_start));
          if (out_item_i.block_end !== want.block_end)
            report_mismatch("block_end", 64'(out_item_i.block_end),
                            64'(want.block_end));
        end
      end

      mismatches_o <= mismatch_cnt;
      pending_o <= word_q.size();
      words_o <= word_cnt;
    end
  end

endmodule

// File: test/tdm_audio_deserializer_core_tb.sv
// Testbench top for the TDM audio deserializer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tdm_audio_deserializer_core_tb;
  import tdmd_pkg::*;

  localparam int unsigned HalfPeriod     = 5;
  localparam int unsigned ResetCycles    = 9;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned StuckLimit     = 5000;
  localparam int unsigned HoldCycles     = 60;
  localparam int unsigned PreambleItems  = 70;
  localparam int unsigned SlotMax        = 8;
  localparam int unsigned PhaseCount     = 10;
  localparam int unsigned FirstUnusedReg = RegSyncMode + 1;
  localparam int unsigned LastReg        = (1 << CfgIdxW) - 1;

  localparam int unsigned PhaseBits  [PhaseCount] = '{1, 4, 32, 0, 63, 5, 2, 8, 3, 0};
  localparam int unsigned PhaseSlots [PhaseCount] = '{1, 3, 8, 0, 15, 9, 5, 2, 4, 0};
  localparam int unsigned PhaseFall  [PhaseCount] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 0};
  localparam int unsigned PhaseLate  [PhaseCount] = '{0, 1, 1, 0, 1, 0, 0, 1, 1, 0};
  localparam int unsigned PhaseItems [PhaseCount] =
    '{90, 90, 150, 120, 150, 90, 80, 80, 80, 100};

  typedef struct packed {
    logic sck;
    logic fsync;
    logic sdata;
  } line_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       words_seen;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  bit                hold_req = 1'b0;
  logic [IndexW-1:0] next_index = '1;
  int unsigned       sent = 0;
  line_t             line_q[$];
  logic              moved;

  always #(HalfPeriod) clk_i = ~clk_i;

  tdm_audio_deserializer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tdm_audio_deserializer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_o      (words_seen)
  );

  assign moved = (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
                 (cfg_valid && cfg_ready_o);

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if (moved) stuck = 0;
      else stuck++;
    end
    $display("Timeout: no handshake for %0d cycles", StuckLimit);
    $display("FAILURE");
    $finish;
  end

  task automatic send_sample(input line_t s);
    in_item_t it;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    it.clock_level = s.sck;
    it.frame_level = s.fsync;
    it.data_bit = s.sdata;
    it.sample_index = next_index;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_index++;
    sent++;
  endtask

  // all writes back to back; valid drops only after the last one
  task automatic write_config(input logic [5:0] bps, input logic [3:0] cpf,
                              input logic fall, input logic late);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] val [5];
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    idx[0] = RegBitsPerSample;
    val[0] = {junk[31:6], bps};
    idx[1] = RegChannelsPerFrame;
    val[1] = {junk[31:4], cpf};
    idx[2] = RegClockEdge;
    val[2] = {junk[31:1], fall};
    idx[3] = RegSyncMode;
    val[3] = {junk[31:1], late};
    idx[4] = CfgIdxW'($urandom_range(LastReg, FirstUnusedReg));
    val[4] = $urandom;
    foreach (idx[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every expected word come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_bit(input logic f, input logic d, input int unsigned h);
    line_t s;
    s = {1'b0, f, d};
    repeat (h) line_q.push_back(s);
    s.sck = 1'b1;
    repeat (h) line_q.push_back(s);
  endtask

  // mostly framed TDM traffic, some line noise
  task automatic build_stream(input int unsigned target, input int unsigned wbits,
                              input int unsigned slots, input bit late);
    line_t       s;
    int unsigned h;
    int unsigned nb;
    int unsigned total;
    int unsigned span;
    line_q.delete();
    while (line_q.size() < target) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 8)) begin
          s = 3'($urandom_range(0, 7));
          line_q.push_back(s);
        end
      end else begin
        h = (wbits > 12) ? 1 : $urandom_range(1, 3);
        nb = wbits;
        if ($urandom_range(0, 9) == 0) nb = wbits + $urandom_range(0, 2) - 1;
        if (nb == 0) nb = 1;
        total = slots * nb + int'(late);
        span = $urandom_range(1, nb);
        for (int unsigned k = 0; k < total; k++) begin
          add_bit(k < span, 1'($urandom_range(0, 1)), h);
        end
      end
    end
  endtask

  initial begin
    line_t       s;
    int unsigned bits;
    int unsigned slots;
    logic        fall;
    logic        late;
    int unsigned wbits;
    int unsigned wslots;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first sample high, long unsynced run, then a short framed sequence
    write_config(6'd3, 4'd2, 1'b0, 1'b0);
    line_q.delete();
    s = {1'b1, 1'b0, 1'b1};
    line_q.push_back(s);
    for (int unsigned k = 0; k < PreambleItems; k++) begin
      s = {k[0], 1'b0, 1'($urandom_range(0, 1))};
      line_q.push_back(s);
    end
    add_bit(1'b1, 1'b1, 1);
    add_bit(1'b0, 1'b0, 1);
    add_bit(1'b0, 1'b1, 1);
    add_bit(1'b0, 1'b1, 1);
    add_bit(1'b0, 1'b1, 1);
    add_bit(1'b0, 1'b1, 1);
    add_bit(1'b0, 1'b0, 1);
    add_bit(1'b0, 1'b0, 1);
    add_bit(1'b1, 1'b0, 1);  // word completes on the sync edge
    add_bit(1'b0, 1'b1, 1);
    add_bit(1'b0, 1'b1, 1);
    while (line_q.size() != 0) send_sample(line_q.pop_front());
    settle();

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      bits = PhaseBits[p];
      slots = PhaseSlots[p];
      fall = PhaseFall[p][0];
      late = PhaseLate[p][0];
      if (p == PhaseCount - 1) begin
        bits = $urandom_range(1, 12);
        slots = $urandom_range(0, 15);
        fall = 1'($urandom_range(0, 1));
        late = 1'($urandom_range(0, 1));
      end
      write_config(6'(bits), 4'(slots), fall, late);

      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 75; end
        default: begin tx_idle_pct = 34; rx_idle_pct = 34; end
      endcase

      case ($urandom_range(0, 2))
        0: next_index = IndexW'({$urandom, $urandom});
        1: next_index = '1 - IndexW'($urandom_range(0, 40));
        default: ;
      endcase

      wbits = (bits == 0) ? int'(DefaultWordBits) : (bits > WordW) ? WordW : bits;
      wslots = (slots == 0) ? 1 : (slots > SlotMax) ? SlotMax : slots;
      build_stream(PhaseItems[p], wbits, wslots, late);
      for (int unsigned k = 0; k < PhaseItems[p]; k++) begin
        if (p == 0 && k == 20) hold_req = 1'b1;
        if (p == 5 && k == PhaseItems[p] / 2) settle();
        send_sample(line_q[k]);
      end
      settle();
    end

    $display("Sent %0d line samples over %0d register settings with gaps, stalls and a hold-off",
             sent, PhaseCount + 1);
    $display("Compared %0d finished words, %0d mismatches, %0d words missing",
             words_seen, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
